// ----- design/kdr_pkg.sv -----
// Package for the key debounce block with auto-repeat.
// Holds phase codes, timing constants, register indexes and field widths.
// No dependencies.
package kdr_pkg;

   localparam int PhaseWidth = 3;
   localparam int CountWidth = 16;
   localparam int CsrIndexWidth = 1;

   typedef logic [PhaseWidth-1:0] phase_type;
   typedef logic [CountWidth-1:0] count_type;

   localparam phase_type PH_IDLE      = 3'd0;
   localparam phase_type PH_DEBOUNCE  = 3'd1;
   localparam phase_type PH_CONFIRMED = 3'd2;
   localparam phase_type PH_WAIT      = 3'd3;
   localparam phase_type PH_REPEAT    = 3'd4;

   localparam count_type DEBOUNCE_TICKS = 16'd15;
   localparam count_type CONFIRM_TICKS  = 16'd5;
   localparam count_type DEFAULT_REPEAT = 16'd20;
   localparam count_type DEFAULT_WAIT   = 16'd150;

   localparam count_type RESET_REPEAT_TIME = 16'd20;
   localparam count_type RESET_REPEAT_WAIT = 16'd500;

   localparam logic [CsrIndexWidth-1:0] CSR_REPEAT_TIME = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CSR_REPEAT_WAIT = 1'b1;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

endpackage

// ----- design/key_debounce_with_repeat.sv -----
// Key debounce and auto-repeat qualifier for one active-low key.
// Takes one item per clock while the request side is not stalled: the item is
// held in an input register, the phase update runs between that register and the
// result register, and a skid register lets a new item in while a result waits.
// The request side stalls only while the input register holds an item and both the
// result and skid registers are full.
// Depends on kdr_pkg.
module key_debounce_with_repeat
   import kdr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_command,
   input  logic                     req_pin_level,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_release_event,
   output logic                     rsp_repeat_event,
   output logic [PhaseWidth-1:0]    rsp_phase,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CountWidth-1:0]    csr_wdata
);

   count_type repeat_time_ff, repeat_wait_ff;

   logic in_valid_ff, in_valid_in;
   logic in_command_ff, in_pin_ff;

   phase_type phase_ff, phase_in;
   count_type count_ff, count_in;

   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_rel_ff, rsp_rel_in, rsp_rep_ff, rsp_rep_in;
   phase_type rsp_phase_ff, rsp_phase_in;

   logic      skid_valid_ff, skid_valid_in;
   logic      skid_rel_ff, skid_rel_in, skid_rep_ff, skid_rep_in;
   phase_type skid_phase_ff, skid_phase_in;

   logic      req_xfer, advance, rsp_xfer;
   logic      press, rel, rep;
   count_type rt, rw;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_time_ff <= RESET_REPEAT_TIME;
         repeat_wait_ff <= RESET_REPEAT_WAIT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_REPEAT_TIME: repeat_time_ff <= csr_wdata;
            CSR_REPEAT_WAIT: repeat_wait_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_stall = in_valid_ff && skid_valid_ff;
   assign req_xfer  = req_valid && !req_stall;
   assign advance   = in_valid_ff && !skid_valid_ff;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign in_valid_in = req_xfer || (in_valid_ff && !advance);

   // Phase and countdown update for the item in the input register.
   always_comb begin
      press    = !in_pin_ff;
      rt       = (repeat_time_ff != '0) ? repeat_time_ff : DEFAULT_REPEAT;
      rw       = (repeat_wait_ff != '0) ? repeat_wait_ff : DEFAULT_WAIT;
      rel      = 1'b0;
      rep      = 1'b0;
      phase_in = phase_ff;
      count_in = count_ff;
      if (in_command_ff == CMD_TICK) begin
         if (count_ff != '0) begin
            count_in = count_ff - 1'b1;
         end
      end else begin
         if (press && phase_ff == PH_IDLE) begin
            phase_in = PH_DEBOUNCE;
            count_in = DEBOUNCE_TICKS;
         end else if (phase_ff != PH_IDLE) begin
            if (press && phase_ff == PH_DEBOUNCE && count_ff == '0) begin
               phase_in = PH_CONFIRMED;
               count_in = CONFIRM_TICKS;
            end else if (!press && (phase_ff == PH_CONFIRMED || phase_ff == PH_WAIT)) begin
               rel      = 1'b1;
               phase_in = PH_IDLE;
            end else if (press && phase_ff == PH_CONFIRMED && count_ff == '0) begin
               phase_in = PH_WAIT;
               count_in = rw;
            end else if (press && phase_ff == PH_WAIT && count_ff == '0) begin
               phase_in = PH_REPEAT;
            end else if (press && phase_ff == PH_REPEAT && count_ff == '0) begin
               count_in = rt;
               rep      = 1'b1;
            end
         end
         // Any phase from wait upward drops back to idle once the key is up.
         if (phase_in >= PH_WAIT && !press) begin
            phase_in = PH_IDLE;
         end
      end
   end

   // Result register with a skid stage behind it.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_xfer;
      rsp_rel_in    = rsp_rel_ff;
      rsp_rep_in    = rsp_rep_ff;
      rsp_phase_in  = rsp_phase_ff;
      skid_valid_in = skid_valid_ff;
      skid_rel_in   = skid_rel_ff;
      skid_rep_in   = skid_rep_ff;
      skid_phase_in = skid_phase_ff;
      if (skid_valid_ff && rsp_xfer) begin
         rsp_valid_in  = 1'b1;
         rsp_rel_in    = skid_rel_ff;
         rsp_rep_in    = skid_rep_ff;
         rsp_phase_in  = skid_phase_ff;
         skid_valid_in = 1'b0;
      end
      if (advance) begin
         if (!rsp_valid_ff || rsp_xfer) begin
            rsp_valid_in = 1'b1;
            rsp_rel_in   = rel;
            rsp_rep_in   = rep;
            rsp_phase_in = phase_in;
         end else begin
            skid_valid_in = 1'b1;
            skid_rel_in   = rel;
            skid_rep_in   = rep;
            skid_phase_in = phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         phase_ff      <= PH_IDLE;
         count_ff      <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_command_ff <= req_command;
         in_pin_ff     <= req_pin_level;
      end
      rsp_rel_ff    <= rsp_rel_in;
      rsp_rep_ff    <= rsp_rep_in;
      rsp_phase_ff  <= rsp_phase_in;
      skid_rel_ff   <= skid_rel_in;
      skid_rep_ff   <= skid_rep_in;
      skid_phase_ff <= skid_phase_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_release_event = rsp_rel_ff;
   assign rsp_repeat_event  = rsp_rep_ff;
   assign rsp_phase         = rsp_phase_ff;

endmodule

// ----- design/kdr_checker.sv -----
// Port-level checker for the key debounce block, bound to its top level.
// Depends on kdr_pkg.
module kdr_checker
   import kdr_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_release_event,
   input logic                  rsp_repeat_event,
   input logic [PhaseWidth-1:0] rsp_phase
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_phase)
         && $stable(rsp_release_event) && $stable(rsp_repeat_event))
      else $error("stalled result changed");

   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_release_event && rsp_repeat_event))
      else $error("release and repeat in one result");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_phase <= PH_REPEAT)
      else $error("phase code out of range");

   a_release_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_release_event |-> rsp_phase == PH_IDLE)
      else $error("release event without return to idle");

   a_repeat_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_repeat_event |-> rsp_phase == PH_REPEAT)
      else $error("repeat event outside the repeating phase");

endmodule

bind key_debounce_with_repeat kdr_checker u_kdr_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_release_event (rsp_release_event),
   .rsp_repeat_event  (rsp_repeat_event),
   .rsp_phase         (rsp_phase)
);
